### sv/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

   localparam int DataWidth  = 16;
   localparam int FracBits   = 14;
   localparam int ProdWidth  = 2 * DataWidth;
   // three products summed
   localparam int TWidth     = ProdWidth + 1;
   localparam int RProdWidth = TWidth + DataWidth;
   // four products summed, with margin
   localparam int RWidth     = RProdWidth + 3;
   localparam int OutShift   = 2 * FracBits;
   localparam int ShWidth    = RWidth - OutShift;

   localparam int NumStages  = 5;

   typedef logic signed [DataWidth-1:0]  data_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [TWidth-1:0]     tval_type;
   typedef logic signed [RProdWidth-1:0] rprod_type;
   typedef logic signed [RWidth-1:0]     rval_type;
   typedef logic signed [ShWidth-1:0]    shval_type;

   typedef struct packed {
      data_type x;
      data_type y;
      data_type z;
      data_type w;
   } quat_type;

   typedef struct packed {
      data_type x;
      data_type y;
      data_type z;
   } vec_type;

   // q * v partial products, named <quat part><vector part>
   typedef struct packed {
      prod_type xx;
      prod_type yy;
      prod_type zz;
      prod_type wx;
      prod_type yz;
      prod_type zy;
      prod_type wy;
      prod_type xz;
      prod_type zx;
      prod_type wz;
      prod_type xy;
      prod_type yx;
   } qv_prod_type;

   typedef struct packed {
      tval_type w;
      tval_type x;
      tval_type y;
      tval_type z;
   } tquat_type;

   // t * conj(q) partial products, named <t part><quat part>
   typedef struct packed {
      rprod_type wx;
      rprod_type xw;
      rprod_type yz;
      rprod_type zy;
      rprod_type wy;
      rprod_type xz;
      rprod_type yw;
      rprod_type zx;
      rprod_type wz;
      rprod_type xy;
      rprod_type yx;
      rprod_type zw;
   } tq_prod_type;

   typedef struct packed {
      rval_type x;
      rval_type y;
      rval_type z;
   } rvec_type;

   localparam rval_type  RoundBias = rval_type'(1) <<< (OutShift - 1);
   localparam shval_type OutMax    = shval_type'(32767);
   localparam shval_type OutMin    = -shval_type'(32768);

endpackage

`default_nettype wire

### sv/quaternion_vector_rotation_unit.sv
`default_nettype none

// Rotates a 16-bit vector by a Q2.14 quaternion, returning the x, y, z parts
// of q * v * conj(q), rounded half up to integers and clipped to signed 16 bits
// (tuser flags a clip). Five register stages: q*v products, t sums, t*conj(q)
// products, r sums, round and saturate. One transaction is taken every cycle
// unless every stage is full and the output is stalled. A stalled output
// backs up the stages one by one, and empty stages fill while the output
// waits, so no transaction is lost or repeated. A quaternion that is not of
// unit length scales the result by |q|^2.
module quaternion_vector_rotation_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48],
   // vec_x[79:64], vec_y[95:80], vec_z[111:96]
   input  wire [111:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // rot_x[15:0], rot_y[31:16], rot_z[47:32]
   output logic [47:0] rsp_tdata,
   // saturated[0]
   output logic [0:0]  rsp_tuser
);

   function automatic logic [qvr_pkg::DataWidth:0] round_sat(qvr_pkg::rval_type r);
      qvr_pkg::rval_type  b;
      qvr_pkg::shval_type s;
      logic [qvr_pkg::DataWidth:0] res;
      b = r + qvr_pkg::RoundBias;
      s = b[qvr_pkg::RWidth-1:qvr_pkg::OutShift];
      if (s > qvr_pkg::OutMax) begin
         res = {1'b1, qvr_pkg::OutMax[qvr_pkg::DataWidth-1:0]};
      end else if (s < qvr_pkg::OutMin) begin
         res = {1'b1, qvr_pkg::OutMin[qvr_pkg::DataWidth-1:0]};
      end else begin
         res = {1'b0, s[qvr_pkg::DataWidth-1:0]};
      end
      return res;
   endfunction

   logic [qvr_pkg::NumStages-1:0] valid_ff;
   logic [qvr_pkg::NumStages-1:0] valid_in;
   logic [qvr_pkg::NumStages-1:0] adv;

   qvr_pkg::quat_type    q_in;
   qvr_pkg::vec_type     v_in;
   qvr_pkg::qv_prod_type p1_in, p1_ff;
   qvr_pkg::quat_type    q1_ff, q2_ff;
   qvr_pkg::tquat_type   t2_in, t2_ff;
   qvr_pkg::tq_prod_type p3_in, p3_ff;
   qvr_pkg::rvec_type    r4_in, r4_ff;
   logic [qvr_pkg::DataWidth:0] sx, sy, sz;
   logic [47:0] out_in, out_ff;
   logic        sat_in, sat_ff;

   // a stage takes new contents when it is empty or its successor moves on
   always_comb begin
      adv[qvr_pkg::NumStages-1] = !valid_ff[qvr_pkg::NumStages-1] || rsp_tready;
      for (int k = qvr_pkg::NumStages - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = adv[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < qvr_pkg::NumStages; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = valid_ff[qvr_pkg::NumStages-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = sat_ff;

   always_comb begin
      q_in.x = req_tdata[15:0];
      q_in.y = req_tdata[31:16];
      q_in.z = req_tdata[47:32];
      q_in.w = req_tdata[63:48];
      v_in.x = req_tdata[79:64];
      v_in.y = req_tdata[95:80];
      v_in.z = req_tdata[111:96];

      p1_in.xx = q_in.x * v_in.x;
      p1_in.yy = q_in.y * v_in.y;
      p1_in.zz = q_in.z * v_in.z;
      p1_in.wx = q_in.w * v_in.x;
      p1_in.yz = q_in.y * v_in.z;
      p1_in.zy = q_in.z * v_in.y;
      p1_in.wy = q_in.w * v_in.y;
      p1_in.xz = q_in.x * v_in.z;
      p1_in.zx = q_in.z * v_in.x;
      p1_in.wz = q_in.w * v_in.z;
      p1_in.xy = q_in.x * v_in.y;
      p1_in.yx = q_in.y * v_in.x;

      t2_in.w = -qvr_pkg::TWidth'(p1_ff.xx) - qvr_pkg::TWidth'(p1_ff.yy)
                - qvr_pkg::TWidth'(p1_ff.zz);
      t2_in.x = qvr_pkg::TWidth'(p1_ff.wx) + qvr_pkg::TWidth'(p1_ff.yz)
                - qvr_pkg::TWidth'(p1_ff.zy);
      t2_in.y = qvr_pkg::TWidth'(p1_ff.wy) - qvr_pkg::TWidth'(p1_ff.xz)
                + qvr_pkg::TWidth'(p1_ff.zx);
      t2_in.z = qvr_pkg::TWidth'(p1_ff.wz) + qvr_pkg::TWidth'(p1_ff.xy)
                - qvr_pkg::TWidth'(p1_ff.yx);

      p3_in.wx = t2_ff.w * q2_ff.x;
      p3_in.xw = t2_ff.x * q2_ff.w;
      p3_in.yz = t2_ff.y * q2_ff.z;
      p3_in.zy = t2_ff.z * q2_ff.y;
      p3_in.wy = t2_ff.w * q2_ff.y;
      p3_in.xz = t2_ff.x * q2_ff.z;
      p3_in.yw = t2_ff.y * q2_ff.w;
      p3_in.zx = t2_ff.z * q2_ff.x;
      p3_in.wz = t2_ff.w * q2_ff.z;
      p3_in.xy = t2_ff.x * q2_ff.y;
      p3_in.yx = t2_ff.y * q2_ff.x;
      p3_in.zw = t2_ff.z * q2_ff.w;

      r4_in.x = -qvr_pkg::RWidth'(p3_ff.wx) + qvr_pkg::RWidth'(p3_ff.xw)
                - qvr_pkg::RWidth'(p3_ff.yz) + qvr_pkg::RWidth'(p3_ff.zy);
      r4_in.y = -qvr_pkg::RWidth'(p3_ff.wy) + qvr_pkg::RWidth'(p3_ff.xz)
                + qvr_pkg::RWidth'(p3_ff.yw) - qvr_pkg::RWidth'(p3_ff.zx);
      r4_in.z = -qvr_pkg::RWidth'(p3_ff.wz) - qvr_pkg::RWidth'(p3_ff.xy)
                + qvr_pkg::RWidth'(p3_ff.yx) + qvr_pkg::RWidth'(p3_ff.zw);

      sx = round_sat(r4_ff.x);
      sy = round_sat(r4_ff.y);
      sz = round_sat(r4_ff.z);
      out_in = {sz[qvr_pkg::DataWidth-1:0], sy[qvr_pkg::DataWidth-1:0],
                sx[qvr_pkg::DataWidth-1:0]};
      sat_in = sx[qvr_pkg::DataWidth] | sy[qvr_pkg::DataWidth] | sz[qvr_pkg::DataWidth];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload: load only when the stage advances over a live transaction
   always_ff @(posedge clock) begin
      if (adv[0] && req_tvalid) begin
         p1_ff <= p1_in;
         q1_ff <= q_in;
      end
      if (adv[1] && valid_ff[0]) begin
         t2_ff <= t2_in;
         q2_ff <= q1_ff;
      end
      if (adv[2] && valid_ff[1]) begin
         p3_ff <= p3_in;
      end
      if (adv[3] && valid_ff[2]) begin
         r4_ff <= r4_in;
      end
      if (adv[4] && valid_ff[3]) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

`ifndef NO_ASSERTIONS
   // input back-pressure only when every stage holds a transaction
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> (&valid_ff))
      else $error("input stalled with an empty stage in the pipeline");

   // a clip flag means some component sits at a range limit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |->
         (rsp_tdata[15:0] == 16'h7fff || rsp_tdata[15:0] == 16'h8000 ||
          rsp_tdata[31:16] == 16'h7fff || rsp_tdata[31:16] == 16'h8000 ||
          rsp_tdata[47:32] == 16'h7fff || rsp_tdata[47:32] == 16'h8000))
      else $error("saturation flag set with no clipped component");

   // nothing emerges in the cycle after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> !rsp_tvalid)
      else $error("output valid straight after reset");
`endif

endmodule

`default_nettype wire
